### src/isst_pkg.sv
`timescale 1ns / 1ps

package isst_pkg;

    // Fixed field widths of the transaction ports
    localparam int PORT_IDX_W = 10;
    localparam int KEY_W      = 32;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // Transaction kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RDL,
        ST_RDH,
        ST_TEST,
        ST_MUL,
        ST_DIV,
        ST_PROBE,
        ST_RDP,
        ST_DONE
    } t_state;

endpackage

### src/isst_ram.sv
`timescale 1ns / 1ps

module isst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/interpolation_search_sorted_table_top.sv
`timescale 1ns / 1ps
// Write transaction: stored in the table RAM when accepted, no result.
// Query: each probe reads the range ends, multiplies, runs the bit-serial restoring divider
//   (IW steps, IW = max(clog2(TABLE_DEPTH), 10)) and reads the probe entry, all through the
//   registered RAM read port (3 reads). The search ends on a probe hit, a failed key range check,
//   a single-entry or flat range, or an empty range.
// One transaction in flight; o_stall is high from query acceptance until the result is queued.
// Reset (synchronous, active low) clears the sequencer and result valid; the table is not cleared.

module interpolation_search_sorted_table_top #(
    parameter int TABLE_DEPTH = isst_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = isst_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input transaction channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_kind,
    input  logic        [isst_pkg::PORT_IDX_W-1:0] i_write_index,
    input  logic signed [isst_pkg::KEY_W-1:0]      i_write_value,
    input  logic        [isst_pkg::PORT_IDX_W-1:0] i_search_low,
    input  logic        [isst_pkg::PORT_IDX_W-1:0] i_search_high,
    input  logic signed [isst_pkg::KEY_W-1:0]      i_search_key,
    // result transaction channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_found,
    output logic        [isst_pkg::PORT_IDX_W-1:0] o_found_index
);

    import isst_pkg::*;

    // Widths: RAM address, internal index, product and divider counter
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (AW > PORT_IDX_W) ? AW : PORT_IDX_W;
    localparam int PW = KEY_W + IW;
    localparam int CW = $clog2(IW + 1);

    // Saturate a port index to the last table entry
    function automatic logic [IW-1:0] clamp_idx(input logic [PORT_IDX_W-1:0] x);
        logic [IW-1:0] v;
        v = IW'(x);
        if (32'(x) >= 32'(TABLE_DEPTH)) begin
            v = IW'(TABLE_DEPTH - 1);
        end
        return v;
    endfunction

    t_state r_state, n_state;

    // Search range, key and fetched end values
    logic        [IW-1:0]    r_low,  n_low;
    logic        [IW-1:0]    r_high, n_high;
    logic        [IW-1:0]    r_pos,  n_pos;
    logic signed [KEY_W-1:0] r_key,  n_key;
    logic signed [KEY_W-1:0] r_vl,   n_vl;
    logic signed [KEY_W-1:0] r_vh,   n_vh;

    // Shared multiply / divide datapath
    logic [KEY_W-1:0] r_num,  n_num;    // key - v[low]
    logic [KEY_W-1:0] r_den,  n_den;    // v[high] - v[low]
    logic [IW-1:0]    r_span, n_span;   // high - low
    logic [PW-1:0]    r_dv,   n_dv;     // {remainder, dividend/quotient}
    logic [CW-1:0]    r_cnt,  n_cnt;

    // Pending answer and result register
    logic                  r_hit,    n_hit;
    logic [IW-1:0]         r_where,  n_where;
    logic                  r_ovalid, n_ovalid;
    logic                  r_ofound, n_ofound;
    logic [PORT_IDX_W-1:0] r_oidx,   n_oidx;

    logic                    w_in_acc;
    logic                    w_we;
    logic [IW-1:0]           w_rd_idx;
    logic [VALUE_WIDTH-1:0]  w_rd_data;
    logic signed [KEY_W-1:0] w_rd_val;
    logic signed [KEY_W:0]   w_kd;
    logic signed [KEY_W:0]   w_dd;
    logic [KEY_W:0]          w_t;
    logic                    w_ge;
    logic [KEY_W:0]          w_r;

    assign w_in_acc = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // Table writes happen straight from the input port; out-of-table indices are dropped
    assign w_we = w_in_acc && (i_kind == KIND_WRITE)
                  && (32'(i_write_index) < 32'(TABLE_DEPTH));

    isst_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_write_index)),
        .i_wdata (i_write_value[VALUE_WIDTH-1:0]),
        .i_raddr (AW'(w_rd_idx)),
        .o_rdata (w_rd_data)
    );

    // Stored entries read back sign-extended
    assign w_rd_val = KEY_W'($signed(w_rd_data));

    // Differences in one extra bit; both are non-negative once the key is in range
    assign w_kd = (KEY_W + 1)'(r_key) - (KEY_W + 1)'(r_vl);
    assign w_dd = (KEY_W + 1)'(r_vh) - (KEY_W + 1)'(r_vl);

    // One restoring division step: quotient fits IW bits, so remainder stays below r_den
    assign w_t  = r_dv[PW-1:IW-1];
    assign w_ge = (w_t >= {1'b0, r_den});
    assign w_r  = w_ge ? (w_t - {1'b0, r_den}) : w_t;

    always_comb begin
        n_state  = r_state;
        n_low    = r_low;
        n_high   = r_high;
        n_pos    = r_pos;
        n_key    = r_key;
        n_vl     = r_vl;
        n_vh     = r_vh;
        n_num    = r_num;
        n_den    = r_den;
        n_span   = r_span;
        n_dv     = r_dv;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_where  = r_where;
        n_ovalid = r_ovalid && i_stall;
        n_ofound = r_ofound;
        n_oidx   = r_oidx;
        w_rd_idx = r_low;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_kind == KIND_QUERY)) begin
                    n_low   = clamp_idx(i_search_low);
                    n_high  = clamp_idx(i_search_high);
                    n_key   = i_search_key;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_low > r_high) begin
                    n_hit   = 1'b0;
                    n_where = '0;
                    n_state = ST_DONE;
                end else begin
                    w_rd_idx = r_low;
                    n_state  = ST_RDL;
                end
            end
            ST_RDL: begin
                n_vl     = w_rd_val;
                w_rd_idx = r_high;
                n_state  = ST_RDH;
            end
            ST_RDH: begin
                n_vh    = w_rd_val;
                n_state = ST_TEST;
            end
            ST_TEST: begin
                if ((r_key < r_vl) || (r_key > r_vh)) begin
                    n_hit   = 1'b0;
                    n_where = '0;
                    n_state = ST_DONE;
                end else if (r_low == r_high) begin
                    n_hit   = (r_vl == r_key);
                    n_where = (r_vl == r_key) ? r_low : '0;
                    n_state = ST_DONE;
                end else if (r_vh == r_vl) begin
                    // flat range: key equals both ends
                    n_hit   = 1'b1;
                    n_where = r_low;
                    n_state = ST_DONE;
                end else begin
                    n_num   = w_kd[KEY_W-1:0];
                    n_den   = w_dd[KEY_W-1:0];
                    n_span  = r_high - r_low;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_dv    = PW'(r_num) * PW'(r_span);
                n_cnt   = CW'(IW);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_dv  = {w_r[KEY_W-1:0], r_dv[IW-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_pos    = r_low + r_dv[IW-1:0];
                w_rd_idx = r_low + r_dv[IW-1:0];
                n_state  = ST_RDP;
            end
            ST_RDP: begin
                priority if (w_rd_val == r_key) begin
                    n_hit   = 1'b1;
                    n_where = r_pos;
                    n_state = ST_DONE;
                end else if (w_rd_val < r_key) begin
                    // moving low past high empties the range
                    if (r_pos == r_high) begin
                        n_hit   = 1'b0;
                        n_where = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_low   = r_pos + 1'b1;
                        n_state = ST_CHECK;
                    end
                end else begin
                    if (r_pos == r_low) begin
                        n_hit   = 1'b0;
                        n_where = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_high  = r_pos - 1'b1;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_hit;
                    n_oidx   = PORT_IDX_W'(r_where);
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low    <= n_low;
        r_high   <= n_high;
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_vl     <= n_vl;
        r_vh     <= n_vh;
        r_num    <= n_num;
        r_den    <= n_den;
        r_span   <= n_span;
        r_dv     <= n_dv;
        r_cnt    <= n_cnt;
        r_hit    <= n_hit;
        r_where  <= n_where;
        r_ofound <= n_ofound;
        r_oidx   <= n_oidx;
    end

    assign o_valid       = r_ovalid;
    assign o_found       = r_ofound;
    assign o_found_index = r_oidx;

    // Reads of the range ends only start on a non-empty range
    a_range_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDL) |-> (r_low <= r_high))
        else $error("range empty while fetching end values");

    // Divider invariant: partial remainder below divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dv[PW-1:IW] < r_den))
        else $error("divider remainder not below divisor");

    // Probe stays inside the current range
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDP) |-> ((r_pos >= r_low) && (r_pos <= r_high)))
        else $error("probe outside search range");

    // A pending result is not overwritten while the consumer stalls
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ovalid && i_stall) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");

    // A query leaves idle; a write transaction does not
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_kind == KIND_QUERY)) |=> (r_state == ST_CHECK))
        else $error("accepted query did not start the search");

endmodule

### verif/interpolation_search_sorted_table_checker.sv
`timescale 1ns / 1ps

module interpolation_search_sorted_table_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic                                   i_kind,
    input  logic        [isst_pkg::PORT_IDX_W-1:0] i_write_index,
    input  logic signed [isst_pkg::KEY_W-1:0]      i_write_value,
    input  logic        [isst_pkg::PORT_IDX_W-1:0] i_search_low,
    input  logic        [isst_pkg::PORT_IDX_W-1:0] i_search_high,
    input  logic signed [isst_pkg::KEY_W-1:0]      i_search_key,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic                                   i_found,
    input  logic        [isst_pkg::PORT_IDX_W-1:0] i_found_index,
    output int                                     o_mismatches,
    output int                                     o_pending,
    output int                                     o_answers,
    output int                                     o_hits
);

    import isst_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct packed {
        logic                  found;
        logic [PORT_IDX_W-1:0] index;
    } t_answer;

    logic signed [KEY_W-1:0] stored_vals [DEPTH];
    t_answer                 outstanding_answers [$];

    // Interpolation search over the shadow table; 64-bit maths keeps the product exact.
    function automatic t_answer interpolate_lookup(input logic [PORT_IDX_W-1:0] lo_in,
                                                   input logic [PORT_IDX_W-1:0] hi_in,
                                                   input logic signed [KEY_W-1:0] key);
        longint  lo;
        longint  hi;
        longint  k;
        longint  vl;
        longint  vh;
        longint  vp;
        longint  pos;
        t_answer ans;
        ans = '0;
        lo  = (lo_in >= DEPTH) ? DEPTH - 1 : lo_in;
        hi  = (hi_in >= DEPTH) ? DEPTH - 1 : hi_in;
        k   = key;
        while (lo <= hi) begin
            vl = stored_vals[int'(lo)];
            vh = stored_vals[int'(hi)];
            if (k < vl || k > vh) break;
            if (lo == hi) begin
                if (vl == k) begin
                    ans.found = 1'b1;
                    ans.index = lo[PORT_IDX_W-1:0];
                end
                break;
            end
            // flat range: key must equal both ends, answer at the low end
            if (vh == vl) begin
                ans.found = 1'b1;
                ans.index = lo[PORT_IDX_W-1:0];
                break;
            end
            pos = lo + ((k - vl) * (hi - lo)) / (vh - vl);
            vp  = stored_vals[int'(pos)];
            if (vp == k) begin
                ans.found = 1'b1;
                ans.index = pos[PORT_IDX_W-1:0];
                break;
            end
            if (vp < k) lo = pos + 1;
            else        hi = pos - 1;
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        o_mismatches++;
        $display("%0t ns checker: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            outstanding_answers.delete();
        end else begin
            // results first, so a stray one cannot pair with a query taken this cycle
            if (i_out_valid && !i_out_stall) begin
                if (outstanding_answers.size() == 0) begin
                    report_mismatch("answer with no query outstanding, index", i_found_index, -1);
                end else begin
                    want = outstanding_answers.pop_front();
                    o_answers++;
                    if (want.found) o_hits++;
                    if (i_found !== want.found) report_mismatch("found", i_found, want.found);
                    if (i_found_index !== want.index)
                        report_mismatch("found_index", i_found_index, want.index);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_WRITE) begin
                    if (i_write_index < DEPTH) stored_vals[i_write_index] = i_write_value;
                end else begin
                    outstanding_answers.push_back(
                        interpolate_lookup(i_search_low, i_search_high, i_search_key));
                end
            end
        end
        o_pending <= outstanding_answers.size();
    end

endmodule

### verif/interpolation_search_sorted_table_top_tb.sv
`timescale 1ns / 1ps

module interpolation_search_sorted_table_top_tb;
    import isst_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int LAST_INDEX   = DEPTH - 1;
    localparam int FILL_LEN     = 64;    // entries rewritten by one window reload
    localparam int PHASE_ITEMS  = 140;   // random transactions per table profile
    localparam int CALM_TAIL    = 100;   // final stretch with no idling on either side
    localparam int DRAIN_CYCLES = 300;   // quiet spell after the last answer

    localparam logic signed [KEY_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // Shapes of a window reload
    typedef enum int {
        FILL_SPREAD,     // spread evenly across the window
        FILL_CLUSTERED,  // long plateaus with rare large jumps
        FILL_DENSE       // small steps, many duplicates
    } t_fill_profile;

    // All block inputs are known from time zero
    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic                        i_kind        = KIND_WRITE;
    logic        [PORT_IDX_W-1:0] i_write_index = '0;
    logic signed [KEY_W-1:0]      i_write_value = '0;
    logic        [PORT_IDX_W-1:0] i_search_low  = '0;
    logic        [PORT_IDX_W-1:0] i_search_high = '0;
    logic signed [KEY_W-1:0]      i_search_key  = '0;
    logic                        i_stall       = 1'b0;

    logic                        o_stall;
    logic                        o_valid;
    logic                        o_found;
    logic        [PORT_IDX_W-1:0] o_found_index;

    int mismatches;
    int pending;
    int answers;
    int hits;

    // Stimulus-side copy of what has been loaded; used to pick interesting keys, to reuse
    // loaded values in the directed table and to keep segment rewrites in ascending order.
    logic signed [KEY_W-1:0] loaded [DEPTH];

    bit calm        = 1'b0;   // set for the closing stretch: no gaps, no stalls
    bit sender_gaps = 1'b0;
    int gap_stretch = 0;
    int items_sent  = 0;
    int writes_sent = 0;
    int queries_sent = 0;

    interpolation_search_sorted_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_write_index (i_write_index),
        .i_write_value (i_write_value),
        .i_search_low  (i_search_low),
        .i_search_high (i_search_high),
        .i_search_key  (i_search_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_found_index (o_found_index)
    );

    interpolation_search_sorted_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_kind        (i_kind),
        .i_write_index (i_write_index),
        .i_write_value (i_write_value),
        .i_search_low  (i_search_low),
        .i_search_high (i_search_high),
        .i_search_key  (i_search_key),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_found       (o_found),
        .i_found_index (o_found_index),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_answers     (answers),
        .o_hits        (hits)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop, far beyond a correct run
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side back-pressure: stall bursts between free runs,
    // now and then a long free stretch. Nothing once the closing stretch begins.
    int  stall_run_left = 0;
    bit  stalling       = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_run_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (stall_run_left == 0) begin
                stalling = ($urandom_range(0, 99) < 35);
                if (stalling)                        stall_run_left = $urandom_range(1, 14);
                else if ($urandom_range(0, 9) == 0)  stall_run_left = $urandom_range(100, 300);
                else                                 stall_run_left = $urandom_range(1, 40);
            end
            stall_run_left--;
            i_stall <= stalling;
        end
    end

    // One transaction on the input channel. Valid stays high across back-to-back
    // transactions; an idle burst drops it first. Returns at the accepting edge.
    task automatic send_txn(input logic kind,
                            input logic [PORT_IDX_W-1:0] widx,
                            input logic signed [KEY_W-1:0] wval,
                            input logic [PORT_IDX_W-1:0] slo,
                            input logic [PORT_IDX_W-1:0] shi,
                            input logic signed [KEY_W-1:0] skey);
        int gap;
        // alternate stretches with and without sender idling
        if (gap_stretch == 0) begin
            sender_gaps = ($urandom_range(0, 2) != 0);
            gap_stretch = $urandom_range(10, 80);
        end
        gap_stretch--;
        if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_write_index <= widx;
        i_write_value <= wval;
        i_search_low  <= slo;
        i_search_high <= shi;
        i_search_key  <= skey;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Unused fields of each transaction carry random junk so nothing leans on them
    task automatic write_entry(input int idx, input longint val);
        loaded[idx] = val[KEY_W-1:0];
        writes_sent++;
        send_txn(KIND_WRITE, idx[PORT_IDX_W-1:0], val[KEY_W-1:0],
                 PORT_IDX_W'($urandom), PORT_IDX_W'($urandom), $urandom);
    endtask

    task automatic run_query(input int lo, input int hi, input logic signed [KEY_W-1:0] key);
        queries_sent++;
        send_txn(KIND_QUERY, PORT_IDX_W'($urandom), $urandom,
                 lo[PORT_IDX_W-1:0], hi[PORT_IDX_W-1:0], key);
    endtask

    // Rewrite one window of entries in ascending order with the given shape,
    // kept between the values of its neighbours
    task automatic fill_table(input t_fill_profile profile);
        int     s;
        longint floor_v;
        longint ceil_v;
        longint room;
        longint acc;
        longint step;
        s       = $urandom_range(0, DEPTH - FILL_LEN);
        floor_v = (s > 0) ? loaded[s - 1] : MOST_NEG;
        ceil_v  = (s + FILL_LEN < DEPTH) ? loaded[s + FILL_LEN] : MOST_POS;
        if (ceil_v < floor_v) ceil_v = floor_v;
        room = (ceil_v - floor_v) / FILL_LEN;
        acc  = floor_v;
        for (int i = 0; i < FILL_LEN; i++) begin
            case (profile)
                FILL_SPREAD: step = $urandom_range(0, 32'(2 * room));
                FILL_DENSE:  step = $urandom_range(0, 3);
                default:     step = ($urandom_range(0, 15) == 0)
                                    ? $urandom_range(0, 32'(8 * room))
                                    : $urandom_range(0, 1);
            endcase
            acc += step;
            if (acc > ceil_v) acc = ceil_v;
            write_entry(s + i, acc);
        end
    endtask

    // Fixed table: evenly spaced over the whole signed range, ends at both extremes,
    // with a flat run over 500..531 for the equal-end-values case.
    task automatic directed_cases();
        longint v;
        longint saved;
        for (int i = 0; i < DEPTH; i++) begin
            if (i == LAST_INDEX)          v = MOST_POS;
            else if (i > 500 && i <= 531) v = loaded[500];
            else                          v = MOST_NEG + longint'(i) * (1 << 22);
            write_entry(i, v);
        end
        run_query(0, LAST_INDEX, MOST_NEG);            // key at the very bottom
        run_query(0, LAST_INDEX, MOST_POS);            // key at the very top
        run_query(0, LAST_INDEX, loaded[700]);         // plain hit
        run_query(0, LAST_INDEX, loaded[700] + 1);     // between entries
        run_query(500, 531, loaded[500]);              // flat range, ends equal
        run_query(505, 520, loaded[500]);              // flat range strictly inside the run
        run_query(300, 300, loaded[300]);              // single-entry range, hit
        run_query(300, 300, loaded[301]);              // single-entry range, miss
        run_query(600, 400, loaded[500]);              // empty range
        run_query(100, 200, loaded[50]);               // key below the range
        run_query(100, 200, loaded[250]);              // key above the range
        run_query(LAST_INDEX, LAST_INDEX, MOST_POS);
        run_query(0, 0, MOST_NEG);
        write_entry(LAST_INDEX, MOST_POS);
        write_entry(0, MOST_NEG);
        // Out-of-order entry: the search must still terminate
        saved = loaded[10];
        write_entry(10, MOST_POS);
        run_query(0, 20, loaded[15]);
        run_query(0, 20, MOST_POS);
        run_query(10, 20, loaded[15]);                 // low end above high end
        write_entry(10, saved);
    endtask

    task automatic random_query();
        int                      lo;
        int                      hi;
        int                      p;
        int                      mode;
        logic signed [KEY_W-1:0] key;
        mode = $urandom_range(0, 99);
        if (mode < 40) begin
            lo = $urandom_range(0, LAST_INDEX);
            hi = $urandom_range(lo, LAST_INDEX);
        end else if (mode < 65) begin
            lo = $urandom_range(0, LAST_INDEX);
            hi = lo + $urandom_range(0, 15);
            if (hi > LAST_INDEX) hi = LAST_INDEX;
        end else if (mode < 80) begin
            lo = 0;
            hi = LAST_INDEX;
        end else if (mode < 90) begin
            lo = $urandom_range(0, LAST_INDEX);
            hi = lo;
        end else begin
            lo = $urandom_range(1, LAST_INDEX);
            hi = $urandom_range(0, lo - 1);
        end
        p    = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
        mode = $urandom_range(0, 99);
        if (mode < 45)      key = loaded[p];
        else if (mode < 60) key = loaded[p] + ($urandom_range(0, 1) ? 1 : -1);
        else if (mode < 70) key = loaded[lo] - $urandom_range(1, 1000);
        else if (mode < 80) key = loaded[hi] + $urandom_range(1, 1000);
        else if (mode < 92) key = $urandom;
        else                key = $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
        run_query(lo, hi, key);
    endtask

    // Mostly ascending segment rewrites that fit between their neighbours,
    // with the odd stray write that breaks the ordering.
    task automatic random_writes();
        int          s;
        int          len;
        longint      floor_v;
        longint      ceil_v;
        longint      prev;
        longint      v;
        int unsigned span;
        if ($urandom_range(0, 99) < 10) begin
            write_entry($urandom_range(0, LAST_INDEX), longint'(signed'($urandom)));
        end else begin
            s   = $urandom_range(0, LAST_INDEX);
            len = $urandom_range(1, 12);
            if (s + len > DEPTH) len = DEPTH - s;
            floor_v = (s > 0) ? loaded[s - 1] : MOST_NEG;
            ceil_v  = (s + len < DEPTH) ? loaded[s + len] : MOST_POS;
            if (ceil_v < floor_v) ceil_v = floor_v;
            prev = floor_v;
            for (int j = 0; j < len; j++) begin
                span = 32'((ceil_v - prev) / (len - j));
                if ($urandom_range(0, 3) == 0) v = prev;
                else                           v = prev + longint'($urandom_range(0, span));
                write_entry(s + j, v);
                prev = v;
            end
        end
    endtask

    // Reshape a window of the table, then a random mix of searches and rewrites
    task automatic run_phase(input t_fill_profile profile, input int budget, input bit calm_end);
        int start;
        fill_table(profile);
        start = items_sent;
        while (items_sent - start < budget) begin
            if (calm_end && items_sent - start >= budget - CALM_TAIL) calm <= 1'b1;
            if ($urandom_range(0, 99) < 55) random_query();
            else                           random_writes();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // every entry is written before the first search, so no probe can hit an unloaded one
        directed_cases();
        run_phase(FILL_SPREAD, PHASE_ITEMS, 1'b0);
        run_phase(FILL_CLUSTERED, PHASE_ITEMS, 1'b0);
        run_phase(FILL_DENSE, PHASE_ITEMS, 1'b1);
        i_valid <= 1'b0;
        // wait out every outstanding answer, then a quiet spell for strays
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d table writes and %0d searches sent, %0d answers compared, %0d hits",
                 writes_sent, queries_sent, answers, hits);
        $display("summary: directed edge cases, then spread, clustered and dense window reloads");
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
src/isst_pkg.sv
src/isst_ram.sv
src/interpolation_search_sorted_table_top.sv
verif/interpolation_search_sorted_table_checker.sv
verif/interpolation_search_sorted_table_top_tb.sv
